// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file ngh_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check, disabled while reset is asserted
`define NGH_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ngh check failed");
// concurrent check, active during reset as well
`define NGH_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("ngh check failed");
`endif

// ===== hw/rtl/ngh_pkg.sv =====
// Types, constants and helpers of the n-gram histogram counter
package ngh_pkg;

    localparam int unsigned ALPHABET_SIZE_DEF = 32;
    localparam int unsigned MAX_GRAM_DEF      = 3;

    localparam int unsigned SYM_IN_W  = 5;
    localparam int unsigned BIN_W     = 15;
    localparam int unsigned BIN_DEPTH = 2 ** BIN_W;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned LEN_W     = 2;
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0]  GRAM_LENGTH_RST = 2'd2;
    localparam logic [STEP_W-1:0] GRAM_STEP_RST   = 8'd1;
    localparam logic [CNT_W-1:0]  CNT_MAX         = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAM_LENGTH = 1'b0,
        CFG_GRAM_STEP   = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [SYM_IN_W-1:0] symbol;
        logic [BIN_W-1:0]    read_bin;
    } t_in_req;

    typedef struct packed {
        logic             counted;
        logic [BIN_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] total_grams;
    } t_out_res;

    typedef struct packed {
        t_cmd             command;
        logic             counted;
        logic [BIN_W-1:0] bin;
        logic [CNT_W-1:0] total;
    } t_hist_req;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/ngh_stream.sv =====
// Symbol window, gram phase and running total of counted grams
module ngh_stream
    import ngh_pkg::*;
#(
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int unsigned MAX_GRAM      = MAX_GRAM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_write,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STEP_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  t_in_req              i_req,
    output t_hist_req            o_hreq
);

    localparam int unsigned SYM_W     = $clog2(ALPHABET_SIZE);
    localparam int unsigned WIN_W     = $clog2(ALPHABET_SIZE ** MAX_GRAM);
    localparam int unsigned SEEN_W    = $clog2(MAX_GRAM + 1);
    localparam int unsigned LW        = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;
    localparam int unsigned ACC_W     = WIN_W + SYM_W + 1;
    localparam int unsigned EXT_W     = (WIN_W > BIN_W) ? WIN_W : BIN_W;
    localparam int unsigned SYM_RANGE = 2 ** SYM_IN_W;

    logic [SYM_W-1:0]  sym_lut [SYM_RANGE];

    logic [LEN_W-1:0]  r_len;
    logic [STEP_W-1:0] r_step;
    logic [SYM_W-1:0]  r_digits [MAX_GRAM];
    logic [SEEN_W-1:0] r_seen;
    logic [STEP_W-1:0] r_phase;
    logic [CNT_W-1:0]  r_total;

    logic [SYM_W-1:0]  n_digits [MAX_GRAM];
    logic [SEEN_W-1:0] n_seen;
    logic [STEP_W-1:0] n_phase;
    logic [CNT_W-1:0]  n_total;

    logic [LW-1:0]     len_x;
    logic [LW-1:0]     eff_len;
    logic [STEP_W-1:0] eff_step;
    logic [ACC_W-1:0]  acc;
    logic [EXT_W-1:0]  win_ext;
    logic [BIN_W-1:0]  gram_bin;
    logic              complete;
    logic              counted;
    logic              is_push;

    for (genvar g = 0; g < SYM_RANGE; g++) begin : g_lut
        localparam int unsigned RED = g % ALPHABET_SIZE;
        assign sym_lut[g] = SYM_W'(RED);
    end

    always_comb begin
        len_x = LW'(r_len);
        if (len_x == '0) begin
            eff_len = LW'(1);
        end else if (len_x > LW'(MAX_GRAM)) begin
            eff_len = LW'(MAX_GRAM);
        end else begin
            eff_len = len_x;
        end
        eff_step = (r_step == '0) ? STEP_W'(1) : r_step;
    end

    always_comb begin
        n_digits[0] = sym_lut[i_req.symbol];
        for (int k = 1; k < MAX_GRAM; k++) begin
            n_digits[k] = r_digits[k-1];
        end
        acc = '0;
        for (int k = MAX_GRAM - 1; k >= 0; k--) begin
            if (LW'(k) < eff_len) begin
                acc = ACC_W'(acc[WIN_W-1:0] * ACC_W'(ALPHABET_SIZE)) + ACC_W'(n_digits[k]);
            end
        end
        win_ext  = EXT_W'(acc[WIN_W-1:0]);
        gram_bin = win_ext[BIN_W-1:0];
    end

    always_comb begin
        n_seen   = (r_seen < SEEN_W'(MAX_GRAM)) ? SEEN_W'(r_seen + 1'b1) : r_seen;
        complete = (LW'(n_seen) >= eff_len);
        n_phase  = r_phase;
        counted  = 1'b0;
        if (complete) begin
            if (n_phase >= eff_step) begin
                n_phase = '0;
            end
            counted = (n_phase == '0);
            n_phase = STEP_W'(n_phase + 1'b1);
            if (n_phase >= eff_step) begin
                n_phase = '0;
            end
        end
        n_total = counted ? sat_inc(r_total) : r_total;
    end

    always_comb begin
        is_push        = (i_req.command == CMD_PUSH);
        o_hreq.command = i_req.command;
        o_hreq.counted = is_push && counted;
        o_hreq.bin     = is_push ? (counted ? gram_bin : '0) : i_req.read_bin;
        o_hreq.total   = is_push ? n_total : r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= GRAM_LENGTH_RST;
            r_step   <= GRAM_STEP_RST;
            r_digits <= '{default: '0};
            r_seen   <= '0;
            r_phase  <= '0;
            r_total  <= '0;
        end else if (i_cfg_write) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRAM_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_GRAM_STEP:   r_step <= i_cfg_data;
            endcase
            r_digits <= '{default: '0};
            r_seen   <= '0;
            r_phase  <= '0;
        end else if (i_accept && is_push) begin
            r_digits <= n_digits;
            r_seen   <= n_seen;
            r_phase  <= n_phase;
            r_total  <= n_total;
        end
    end

endmodule

// ===== hw/rtl/ngh_hist.sv =====
// Histogram memory with read-modify-write, forwarding and clearing sweep
module ngh_hist
    import ngh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_hist_req i_hreq,
    input  logic      i_out_free,
    output logic      o_busy,
    output logic      o_res_valid,
    output t_out_res  o_res
);

    logic [CNT_W-1:0] r_mem [BIN_DEPTH];
    logic [CNT_W-1:0] r_mem_q;
    logic             r_s1_valid;
    t_hist_req        r_s1;
    logic             r_fwd;
    logic [CNT_W-1:0] r_fwd_val;
    logic             r_clr_busy;
    logic [BIN_W-1:0] r_clr_addr;

    logic             s1_fire;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;

    always_comb begin
        s1_fire = r_s1_valid && i_out_free;
        cur_cnt = r_fwd ? r_fwd_val : r_mem_q;
        new_cnt = r_s1.counted ? sat_inc(cur_cnt) : cur_cnt;
        wr_en   = r_clr_busy || (s1_fire && r_s1.counted);
        wr_addr = r_clr_busy ? r_clr_addr : r_s1.bin;
        wr_data = r_clr_busy ? '0 : new_cnt;
    end

    always_comb begin
        o_busy            = r_clr_busy;
        o_res_valid       = r_s1_valid;
        o_res.counted     = r_s1.counted;
        o_res.bin_index   = r_s1.bin;
        o_res.bin_count   = (r_s1.command == CMD_PUSH && !r_s1.counted) ? '0 : new_cnt;
        o_res.total_grams = r_s1.total;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_accept) begin
            r_mem_q <= r_mem[i_hreq.bin];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_fire && r_s1.counted && (r_s1.bin == i_hreq.bin);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1      <= i_hreq;
            r_fwd_val <= new_cnt;
        end
    end

endmodule

// ===== hw/rtl/ngram_histogram_counter_top.sv =====
// Top level of the n-gram histogram counter
// Takes one request per cycle while o_in_stall is low, push or bin read, and
// returns one result per request via the memory stage and output register;
// the sustained rate of one per cycle is set by the one-read, one-write
// read-modify-write of the 32768 x 32 bin memory, with the count written back
// and forwarded to a following request on the same bin. After reset all 32768
// bins are cleared in a sweep, one bin per cycle, with o_in_stall high;
// configuration writes are taken at any time and restart the symbol window.
module ngram_histogram_counter_top
    import ngh_pkg::*;
#(
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int unsigned MAX_GRAM      = MAX_GRAM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_res             o_out_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STEP_W-1:0]    i_cfg_data
);

    t_hist_req hreq;
    t_out_res  res;
    logic      res_valid;
    logic      busy;
    logic      accept;
    logic      out_free;
    logic      r_out_valid;
    t_out_res  r_out;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = busy || (res_valid && !out_free);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    ngh_stream #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .MAX_GRAM     (MAX_GRAM)
    ) u_stream (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_write(i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_req      (i_in_req),
        .o_hreq     (hreq)
    );

    ngh_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_hreq     (hreq),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

endmodule

// ===== hw/rtl/ngh_checker.sv =====
// Port-level checks of the n-gram histogram counter and their binding
`include "assert_macros.svh"

module ngh_checker
    import ngh_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_res             o_out_res
);

    logic [CNT_W-1:0] r_last_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_total <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_last_total <= o_out_res.total_grams;
        end
    end

    `NGH_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
    `NGH_ASSERT_RST(a_counted_nonzero, i_clk, i_rst_n, o_out_valid && o_out_res.counted |-> (o_out_res.bin_count != '0) && (o_out_res.total_grams != '0))
    `NGH_ASSERT_RST(a_total_monotonic, i_clk, i_rst_n, o_out_valid && !i_out_stall |-> o_out_res.total_grams >= r_last_total)
    `NGH_ASSERT(a_clear_after_reset, i_clk, !i_rst_n |=> o_in_stall)

endmodule

bind ngram_histogram_counter_top ngh_checker u_ngh_checker (.*);

// ===== tb/ngram_histogram_counter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the n-gram histogram counter top level
module ngram_histogram_counter_top_tb;
    import ngh_pkg::*;

    localparam int unsigned LIMIT        = 400000;
    localparam int unsigned SETTLE       = 6;
    localparam int unsigned PRESSURE_AT  = 900;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned IDLE_PERCENT = 13;

    logic                 i_clk       = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    t_in_req              in_req      = '0;
    logic                 out_stall   = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [STEP_W-1:0]    cfg_data    = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_res             o_out_res;
    logic                 o_cfg_ready;

    t_in_req  pending_requests[$];
    t_out_res expected_results[$];

    bit                calm          = 1'b0;
    int unsigned       accepted_reqs = 0;
    int unsigned       hold_left     = 0;
    bit                hold_done     = 1'b0;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count   = 0;

    logic [LEN_W-1:0]  len_reg      = GRAM_LENGTH_RST;
    logic [STEP_W-1:0] step_reg     = GRAM_STEP_RST;
    longint unsigned   window_model = 0;
    int unsigned       seen_model   = 0;
    int unsigned       phase_model  = 0;
    bit [CNT_W-1:0]    bin_model [BIN_DEPTH];
    bit [CNT_W-1:0]    total_model  = '0;
    longint unsigned   recent_syms  = 0;

    ngram_histogram_counter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned gram_len_eff();
        if (len_reg == '0) return 1;
        if (len_reg > MAX_GRAM_DEF) return MAX_GRAM_DEF;
        return 32'(len_reg);
    endfunction

    function automatic longint unsigned gram_span(int unsigned n);
        longint unsigned m;
        m = 1;
        repeat (n) m = m * ALPHABET_SIZE_DEF;
        return m;
    endfunction

    function automatic t_out_res next_histogram_result(t_in_req req);
        t_out_res         res;
        int unsigned      n;
        int unsigned      stride;
        logic [BIN_W-1:0] b;
        res = '0;
        if (req.command == CMD_READ) begin
            res.bin_index = req.read_bin;
            res.bin_count = bin_model[req.read_bin];
        end else begin
            n = gram_len_eff();
            stride = (step_reg == '0) ? 1 : 32'(step_reg);
            window_model = (window_model * ALPHABET_SIZE_DEF
                            + (req.symbol % ALPHABET_SIZE_DEF)) % gram_span(n);
            if (seen_model < MAX_GRAM_DEF) seen_model++;
            if (seen_model >= n) begin
                if (phase_model >= stride) phase_model = 0;
                if (phase_model == 0) begin
                    b = window_model[BIN_W-1:0];
                    if (bin_model[b] != CNT_MAX) bin_model[b] = bin_model[b] + 1'b1;
                    if (total_model != CNT_MAX) total_model = total_model + 1'b1;
                    res.counted   = 1'b1;
                    res.bin_index = b;
                    res.bin_count = bin_model[b];
                end
                phase_model++;
                if (phase_model >= stride) phase_model = 0;
            end
        end
        res.total_grams = total_model;
        return res;
    endfunction

    task automatic check_field(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic queue_request(t_cmd cmd, logic [SYM_IN_W-1:0] sym, logic [BIN_W-1:0] bin);
        t_in_req r;
        r.command  = cmd;
        r.symbol   = sym;
        r.read_bin = bin;
        pending_requests.push_back(r);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [STEP_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRAM_LENGTH) len_reg = val[LEN_W-1:0];
        else step_reg = val;
        window_model = 0;
        seen_model   = 0;
        phase_model  = 0;
    endtask

    task automatic run_phase(int unsigned count, bit narrow);
        logic [SYM_IN_W-1:0] sym;
        logic [BIN_W-1:0]    bin;
        recent_syms = 0;
        repeat (count) begin
            sym = narrow ? SYM_IN_W'($urandom_range(0, 3) * 10) : SYM_IN_W'($urandom_range(0, 31));
            if ($urandom_range(0, 99) < 80) begin
                queue_request(CMD_PUSH, sym, BIN_W'($urandom_range(0, 32767)));
                recent_syms = (recent_syms * ALPHABET_SIZE_DEF + sym)
                              % gram_span(MAX_GRAM_DEF);
            end else begin
                if ($urandom_range(0, 1) == 1)
                    bin = BIN_W'(recent_syms % gram_span(gram_len_eff()));
                else
                    bin = BIN_W'($urandom_range(0, 32767));
                queue_request(CMD_READ, sym, bin);
            end
        end
        drain();
    endtask

    always @(posedge i_clk) begin : driver
        logic fire;
        fire = in_valid && !o_in_stall;
        if (rst_n) begin
            if (fire) begin
                expected_results.push_back(next_histogram_result(in_req));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!in_valid || fire) begin
                if (pending_requests.size() != 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    in_valid <= 1'b1;
                    in_req   <= pending_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver_hold
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_reqs >= PRESSURE_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        out_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin : monitor
        t_out_res want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: %h", $time, o_out_res);
            end else begin
                want = expected_results.pop_front();
                check_field("counted", CNT_W'(want.counted), CNT_W'(o_out_res.counted));
                check_field("bin_index", CNT_W'(want.bin_index),
                            CNT_W'(o_out_res.bin_index));
                check_field("bin_count", want.bin_count, o_out_res.bin_count);
                check_field("total_grams", want.total_grams, o_out_res.total_grams);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("ngram_histogram_counter_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        queue_request(CMD_READ, 5'd31, 15'd0);
        queue_request(CMD_READ, 5'd31, 15'd32767);
        queue_request(CMD_PUSH, 5'd31, 15'd32767);
        queue_request(CMD_PUSH, 5'd31, 15'd0);
        queue_request(CMD_PUSH, 5'd31, 15'd0);
        queue_request(CMD_PUSH, 5'd31, 15'd0);
        queue_request(CMD_PUSH, 5'd0, 15'd21845);
        queue_request(CMD_PUSH, 5'd0, 15'd10922);
        queue_request(CMD_PUSH, 5'd0, 15'd0);
        queue_request(CMD_READ, 5'd0, 15'd1023);
        queue_request(CMD_READ, 5'd0, 15'd992);
        queue_request(CMD_READ, 5'd0, 15'd0);
        queue_request(CMD_PUSH, 5'd21, 15'd0);
        queue_request(CMD_PUSH, 5'd10, 15'd0);
        queue_request(CMD_READ, 5'd0, 15'd682);
        queue_request(CMD_READ, 5'd0, 15'd16383);
        drain();

        write_reg(CFG_GRAM_LENGTH, 8'd3);
        write_reg(CFG_GRAM_STEP, 8'd1);
        run_phase(250, 1'b1);

        write_reg(CFG_GRAM_LENGTH, 8'd1);
        write_reg(CFG_GRAM_STEP, 8'd255);
        run_phase(200, 1'b0);

        calm = 1'b1;
        write_reg(CFG_GRAM_LENGTH, 8'd252);
        write_reg(CFG_GRAM_STEP, 8'd0);
        run_phase(250, 1'b1);
        calm = 1'b0;

        write_reg(CFG_GRAM_LENGTH, 8'd2);
        write_reg(CFG_GRAM_STEP, 8'd2);
        run_phase(300, 1'b0);

        repeat (4) begin
            write_reg(CFG_GRAM_LENGTH, STEP_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_GRAM_STEP, STEP_W'($urandom_range(1, 3)));
            else
                write_reg(CFG_GRAM_STEP, STEP_W'($urandom_range(0, 255)));
            run_phase(225, 1'($urandom_range(0, 1)));
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ngram_histogram_counter_top_tb: PASS");
        else
            $display("ngram_histogram_counter_top_tb: FAIL");
        $finish;
    end

endmodule
